[src/tsa_pkg.sv]
// ----------------------------------------------------------------------------
// Tile slot allocator package
// Shared constants, codes and the slot record carried along the cell chain.
// ----------------------------------------------------------------------------
package tsa_pkg;

    localparam int TSA_SLOTS       = 15;
    localparam int TSA_SCENE_DEPTH = 32;

    localparam logic [7:0] UNLOADED_MARK = 8'hFF;

    localparam logic [2:0] OP_LOAD_DEF   = 3'd0;
    localparam logic [2:0] OP_UNLOAD_DEF = 3'd1;
    localparam logic [2:0] OP_LOAD_RES   = 3'd2;
    localparam logic [2:0] OP_ENSURE     = 3'd3;
    localparam logic [2:0] OP_LVL_RESET  = 3'd4;
    localparam logic [2:0] OP_SCENE_INIT = 3'd5;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FAILED  = 2'd1;
    localparam logic [1:0] ST_NOTHING = 2'd2;

    typedef struct packed {
        logic [7:0]  refs;
        logic [7:0]  base;
        logic [7:0]  size;
        logic [23:0] sprite;
    } t_slot;

endpackage

[src/tsa_cell.sv]
// ----------------------------------------------------------------------------
// Slot cell
// One slot of the rotating slot ring; loads its neighbour's record on shift.
// ----------------------------------------------------------------------------
module tsa_cell
    import tsa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  logic  i_clear,
    input  t_slot i_d,
    output t_slot o_q
);

    logic [7:0]  r_refs;
    logic [7:0]  r_base;
    logic [7:0]  r_size;
    logic [23:0] r_sprite;

    // control part: count, base and size reset to the free, never-used mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_refs <= '0;
            r_base <= UNLOADED_MARK;
            r_size <= UNLOADED_MARK;
        end else if (i_shift) begin
            r_refs <= i_d.refs;
            r_base <= i_d.base;
            r_size <= i_d.size;
        end
    end

    // sprite id holds no reset value
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sprite <= i_d.sprite;
        end
    end

    assign o_q = {r_refs, r_base, r_size, r_sprite};

endmodule

[src/tsa_scene.sv]
// ----------------------------------------------------------------------------
// Scene sprite cache
// Base tile per scene sprite; entries without a valid bit read as unloaded.
// Read data is registered: it follows the read address in the next cycle.
// ----------------------------------------------------------------------------
module tsa_scene
    import tsa_pkg::*;
#(
    parameter int DEPTH = TSA_SCENE_DEPTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0]       r_base [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [7:0]       r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_base[i_waddr] <= i_wdata;
        end
        r_rdata <= r_valid[i_raddr] ? r_base[i_raddr] : UNLOADED_MARK;
    end

    assign o_rdata = r_rdata;

endmodule

[src/refcounted_tile_slot_allocator_unit.sv]
// ----------------------------------------------------------------------------
// Reference-counted tile slot allocator
// Hands out sprite tile regions from an 8-bit bump pointer, with shared slots.
// ----------------------------------------------------------------------------
// One beat in, one beat out. The slot table is a ring of SLOTS cells that
// rotates one place per cycle while a search runs, past a single update point
// at its head, so every search pass walks the ring once in slot order and
// leaves it where it began. Each beat is captured, then decoded; a cache-hit
// load or an unload then walks the ring once, and a deferred load that finds no
// slot with the same sprite walks it twice (sprite pass then free-slot pass).
// Reserved loads, ensures, level reset, scene init, unknown codes, deferred
// loads of zero tiles and unloads of an unloaded base skip the walk. The result
// then moves into the output register once it is empty or not stalled. The next
// beat is taken as soon as the block is idle, even while a result still waits
// in the output register. Write sprites_in_scene only while idle.
// ----------------------------------------------------------------------------
module refcounted_tile_slot_allocator_unit
    import tsa_pkg::*;
#(
    parameter int SLOTS       = TSA_SLOTS,
    parameter int SCENE_DEPTH = TSA_SCENE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_operation,
    input  logic [23:0] i_sprite_id,
    input  logic [7:0]  i_tile_count,
    input  logic [5:0]  i_scene_index,
    input  logic [7:0]  i_current_base,
    input  logic [7:0]  i_start_tile,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_tile_base,
    output logic [7:0]  o_count
);

    localparam int CW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW = (SCENE_DEPTH > 1) ? $clog2(SCENE_DEPTH) : 1;
    localparam int IW = (AW > 6) ? AW : 6;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DEC  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    localparam logic [1:0] M_HIT  = 2'd0;
    localparam logic [1:0] M_SPR  = 2'd1;
    localparam logic [1:0] M_FREE = 2'd2;
    localparam logic [1:0] M_UNL  = 2'd3;

    // configuration and captured beat
    logic [5:0]  r_cfg;
    logic [2:0]  r_op;
    logic [23:0] r_id;
    logic [7:0]  r_n;
    logic [5:0]  r_idx;
    logic [7:0]  r_cur;
    logic [7:0]  r_start;

    // control
    logic [1:0]    r_state, n_state;
    logic [1:0]    r_mode, n_mode;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_found, n_found;
    logic [7:0]    r_ptr, n_ptr;
    logic [7:0]    r_total, n_total;
    logic [7:0]    r_b, n_b;

    // pending result and output register
    logic [1:0] r_rst, n_rst;
    logic [7:0] r_rbase, n_rbase;
    logic [7:0] r_rcnt, n_rcnt;
    logic       r_ovalid;
    logic [1:0] r_ostatus;
    logic [7:0] r_obase;
    logic [7:0] r_ocnt;

    // ring and scene cache hooks
    t_slot        q [SLOTS];
    t_slot        head_mod;
    logic         ring_shift;
    logic         slot_clear;
    logic         scene_clear;
    logic         scene_we;
    logic [7:0]   scene_wdata;
    logic [7:0]   scene_rdata;
    logic [AW-1:0] scene_addr;
    logic [AW-1:0] scene_raddr;
    logic [IW-1:0] idx_x;
    logic [IW-1:0] idx_in;
    logic         in_cache;
    logic         cached;
    logic         head_live;
    logic         last_cell;

    assign idx_x      = IW'(r_idx);
    assign idx_in     = IW'(i_scene_index);
    assign scene_addr = idx_x[AW-1:0];
    // read the cache at the accepting edge so the entry is ready for decode
    assign scene_raddr = (r_state == S_IDLE) ? idx_in[AW-1:0] : scene_addr;
    assign in_cache   = ({3'b000, r_idx} < 9'(SCENE_DEPTH)) && (r_idx < r_cfg);
    assign cached     = in_cache && (scene_rdata != UNLOADED_MARK);
    assign head_live  = (q[0].refs != 8'd0);
    assign last_cell  = (r_cnt == CW'(SLOTS - 1));

    // ring of slot cells; the tail reloads the head as modified this cycle
    for (genvar g = 0; g < SLOTS; g++) begin : g_ring
        t_slot d;
        if (g == SLOTS - 1) begin : g_tail
            assign d = head_mod;
        end else begin : g_mid
            assign d = q[g + 1];
        end
        tsa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (ring_shift),
            .i_clear (slot_clear),
            .i_d     (d),
            .o_q     (q[g])
        );
    end

    tsa_scene #(
        .DEPTH (SCENE_DEPTH)
    ) u_scene (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (scene_clear),
        .i_we    (scene_we),
        .i_waddr (scene_addr),
        .i_wdata (scene_wdata),
        .i_raddr (scene_raddr),
        .o_rdata (scene_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_data;
        end
    end

    // capture the beat
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_op    <= i_operation;
            r_id    <= i_sprite_id;
            r_n     <= i_tile_count;
            r_idx   <= i_scene_index;
            r_cur   <= i_current_base;
            r_start <= i_start_tile;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_cnt       = r_cnt;
        n_found     = r_found;
        n_ptr       = r_ptr;
        n_total     = r_total;
        n_b         = r_b;
        n_rst       = r_rst;
        n_rbase     = r_rbase;
        n_rcnt      = r_rcnt;
        head_mod    = q[0];
        ring_shift  = 1'b0;
        slot_clear  = 1'b0;
        scene_clear = 1'b0;
        scene_we    = 1'b0;
        scene_wdata = r_ptr;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_FIN;
                n_cnt   = '0;
                n_found = 1'b0;
                unique case (r_op) inside
                    OP_LOAD_DEF: begin
                        if (r_n == 8'd0) begin
                            {n_rst, n_rbase, n_rcnt} = {ST_FAILED, 8'd0, 8'd0};
                        end else if (cached) begin
                            n_b     = scene_rdata;
                            n_mode  = M_HIT;
                            n_state = S_SCAN;
                            {n_rst, n_rbase, n_rcnt} = {ST_DONE, scene_rdata, 8'd1};
                        end else begin
                            n_mode  = M_SPR;
                            n_state = S_SCAN;
                            {n_rst, n_rbase, n_rcnt} = {ST_FAILED, 8'd0, 8'd0};
                        end
                    end
                    OP_UNLOAD_DEF: begin
                        if (r_cur == UNLOADED_MARK) begin
                            {n_rst, n_rbase, n_rcnt} = {ST_NOTHING, 8'd0, 8'd0};
                        end else begin
                            n_mode  = M_UNL;
                            n_state = S_SCAN;
                            {n_rst, n_rbase, n_rcnt} = {ST_DONE, UNLOADED_MARK, 8'd0};
                        end
                    end
                    OP_LOAD_RES, OP_ENSURE: begin
                        if (cached) begin
                            {n_rst, n_rbase, n_rcnt} = {ST_DONE, scene_rdata, 8'd1};
                        end else if ((r_op == OP_ENSURE && !in_cache) || r_n == 8'd0) begin
                            {n_rst, n_rbase, n_rcnt} = {ST_FAILED, 8'd0, 8'd0};
                        end else begin
                            scene_we = in_cache;
                            n_ptr    = r_ptr + r_n;
                            {n_rst, n_rbase, n_rcnt} = {ST_DONE, r_ptr, r_n};
                        end
                    end
                    OP_LVL_RESET: begin
                        slot_clear = 1'b1;
                        n_ptr      = r_ptr - r_total;
                        n_total    = '0;
                        {n_rst, n_rbase, n_rcnt} = {ST_DONE, r_ptr - r_total, 8'd0};
                    end
                    OP_SCENE_INIT: begin
                        slot_clear  = 1'b1;
                        scene_clear = 1'b1;
                        n_ptr       = r_start;
                        n_total     = '0;
                        {n_rst, n_rbase, n_rcnt} = {ST_DONE, r_start, 8'd0};
                    end
                    default: begin
                        {n_rst, n_rbase, n_rcnt} = {ST_NOTHING, 8'd0, 8'd0};
                    end
                endcase
            end
            S_SCAN: begin
                ring_shift = 1'b1;
                n_cnt      = r_cnt + CW'(1);
                if (!r_found) begin
                    case (r_mode)
                        M_HIT: begin
                            if (head_live && q[0].base == r_b) begin
                                if (q[0].refs != 8'hFF) head_mod.refs = q[0].refs + 8'd1;
                                n_found = 1'b1;
                            end
                        end
                        M_SPR: begin
                            if (head_live && q[0].sprite == r_id) begin
                                if (q[0].refs != 8'hFF) head_mod.refs = q[0].refs + 8'd1;
                                n_found = 1'b1;
                                {n_rst, n_rbase, n_rcnt} = {ST_DONE, q[0].base, q[0].size};
                            end
                        end
                        M_FREE: begin
                            if (!head_live && q[0].base == UNLOADED_MARK) begin
                                // never used: take a fresh region from the pointer
                                head_mod = '{refs: 8'd1, base: r_ptr, size: r_n, sprite: r_id};
                                scene_we = in_cache;
                                n_ptr    = r_ptr + r_n;
                                n_total  = r_total + r_n;
                                n_found  = 1'b1;
                                {n_rst, n_rbase, n_rcnt} = {ST_DONE, r_ptr, r_n};
                            end else if (!head_live && q[0].size >= r_n) begin
                                // freed and large enough: reuse its region
                                head_mod.refs   = 8'd1;
                                head_mod.sprite = r_id;
                                scene_we        = in_cache;
                                scene_wdata     = q[0].base;
                                n_found         = 1'b1;
                                {n_rst, n_rbase, n_rcnt} = {ST_DONE, q[0].base, r_n};
                            end
                        end
                        default: begin
                            if (head_live && q[0].base == r_cur) begin
                                head_mod.refs = q[0].refs - 8'd1;
                                n_found       = 1'b1;
                            end
                        end
                    endcase
                end
                if (last_cell) begin
                    n_cnt = '0;
                    if (r_mode == M_SPR && !n_found) begin
                        n_mode = M_FREE;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            default: begin
                if (!r_ovalid || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= M_HIT;
            r_cnt   <= '0;
            r_found <= 1'b0;
            r_ptr   <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_cnt   <= n_cnt;
            r_found <= n_found;
            r_ptr   <= n_ptr;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b     <= n_b;
        r_rst   <= n_rst;
        r_rbase <= n_rbase;
        r_rcnt  <= n_rcnt;
    end

    // output register: load when the finished result finds it free or leaving
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_FIN && (!r_ovalid || !i_stall)) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && (!r_ovalid || !i_stall)) begin
            r_ostatus <= r_rst;
            r_obase   <= r_rbase;
            r_ocnt    <= r_rcnt;
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_status    = r_ostatus;
    assign o_tile_base = r_obase;
    assign o_count     = r_ocnt;

    // the walk never runs past the last cell
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_cnt <= CW'(SLOTS - 1))
        else $error("slot walk counter out of range");

    // a new result only appears out of the finish state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_FIN)
        else $error("result raised outside finish");

    // during the free-slot pass the result is a failure until a slot is taken
    a_free_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_mode == M_FREE) |-> (r_rst == ST_FAILED || r_found))
        else $error("free pass result without a slot");

endmodule
